@@ rtl/core/aes_pkg.sv @@
`timescale 1ns / 1ps
package aes_pkg;

  localparam int DEF_MAX_EVENTS  = 32;
  localparam int DEF_WINDOW_DAYS = 7;

  localparam int DAY_W = 21;
  localparam int REQ_W = 2;
  localparam int POT_W = 16;
  localparam int SIM_W = 17;
  localparam int MUL_W = 64;
  localparam int MUL_B = 32;
  localparam int FRAC_W = 16;

  localparam logic [SIM_W-1:0] SIM_ONE = 17'h10000;

endpackage

@@ rtl/core/aes_ram.sv @@
`timescale 1ns / 1ps
module aes_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/aes_solver.sv @@
`timescale 1ns / 1ps
module aes_solver #(
  parameter int MAX_EVENTS  = aes_pkg::DEF_MAX_EVENTS,
  parameter int WINDOW_DAYS = aes_pkg::DEF_WINDOW_DAYS,
  localparam int IW  = $clog2(MAX_EVENTS + 1),
  localparam int CW  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1,
  localparam int DAW = CW + 2,
  localparam int WW  = $clog2(WINDOW_DAYS * MAX_EVENTS + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic                              cat_i,
  input  logic [IW-1:0]                     m_i,
  input  logic [IW-1:0]                     n_i,
  output logic [DAW-1:0]                    day_raddr_o,
  input  logic signed [aes_pkg::DAY_W-1:0]  day_rdata_i,
  output logic                              done_o,
  output logic [WW-1:0]                     weight_o
);

  localparam int PW  = aes_pkg::POT_W;
  localparam int DW  = aes_pkg::DAY_W;
  localparam int KW  = $clog2(WINDOW_DAYS + 1);
  localparam int CEW = 2 * PW + 2 * IW + 1;
  localparam logic signed [PW-1:0] INF = {1'b0, {(PW-1){1'b1}}};

  typedef enum logic [4:0] {
    S_IDLE, S_INIT, S_RST_RD, S_RST_WR, S_STEP_RD, S_STEP_GOT, S_PREP,
    S_SCAN_RD, S_SCAN_GOT, S_UPD_RD, S_UPD_GOT, S_UPD_ROW,
    S_AUG_RD, S_AUG_GOT, S_AUG_GOT2, S_TOT_RD, S_TOT_GOT, S_TOT_D1, S_TOT_D2
  } state_e;

  function automatic logic [KW-1:0] pair_wt(input logic signed [DW-1:0] a,
                                            input logic signed [DW-1:0] b,
                                            input logic ok);
    logic signed [DW:0] d;
    logic [DW:0] g;
    d = (DW+1)'(a) - (DW+1)'(b);
    g = d[DW] ? -d : d;
    if (ok && g < (DW+1)'(WINDOW_DAYS)) begin
      pair_wt = KW'((DW+1)'(WINDOW_DAYS) - g);
    end else begin
      pair_wt = '0;
    end
  endfunction

  state_e state_q;
  logic [IW-1:0] i_q, j_q, j0_q, j1_q, i0_q, own_q, size_q, m_q, n_q;
  logic signed [PW-1:0] delta_q, u_q;
  logic signed [DW-1:0] rday_q;
  logic [WW-1:0] total_q;
  logic [CEW-1:0] cq_q;
  logic cat_q, done_q;

  logic col_we, row_we;
  logic [IW-1:0] col_waddr, col_raddr, row_waddr, row_raddr;
  logic [CEW-1:0] col_wdata, col_rdata;
  logic [PW-1:0] row_wdata, row_rdata;

  logic signed [PW-1:0] c_v, c_mn, nmn;
  logic [IW-1:0] c_own, c_way, own_m1, j_m1;
  logic c_used, upd, nlt, last_j;
  logic [KW-1:0] wt;
  logic signed [PW+1:0] cur;
  logic [1:0] la, lb;

  assign c_used = col_rdata[0];
  assign c_mn   = col_rdata[PW:1];
  assign c_way  = col_rdata[PW+IW:PW+1];
  assign c_own  = col_rdata[PW+2*IW:PW+IW+1];
  assign c_v    = col_rdata[CEW-1:PW+2*IW+1];
  assign own_m1 = c_own - IW'(1);
  assign j_m1   = j_q - IW'(1);
  assign la     = {cat_q, 1'b0};
  assign lb     = {cat_q, 1'b1};
  assign last_j = (j_q == size_q);

  assign wt  = pair_wt(rday_q, day_rdata_i,
                       (state_q == S_TOT_D2) || ((i0_q <= m_q) && (j_q <= n_q)));
  assign cur = $signed(-(PW+2)'(wt)) - (PW+2)'(u_q) - (PW+2)'(c_v);
  assign upd = cur < (PW+2)'(c_mn);
  assign nmn = upd ? cur[PW-1:0] : c_mn;
  assign nlt = nmn < delta_q;

  always_comb begin
    col_we      = 1'b0;
    col_waddr   = j_q;
    col_wdata   = '0;
    col_raddr   = j_q;
    row_we      = 1'b0;
    row_waddr   = j_q;
    row_wdata   = '0;
    row_raddr   = c_own;
    day_raddr_o = {lb, j_m1[CW-1:0]};
    unique case (state_q)
      S_INIT: begin
        col_we    = 1'b1;
        col_wdata = {{PW{1'b0}}, {IW{1'b0}}, {IW{1'b0}}, INF, 1'b0};
        row_we    = 1'b1;
      end
      S_RST_WR: begin
        col_we    = 1'b1;
        col_wdata = {c_v, (j_q == '0) ? i_q : c_own, c_way, INF, 1'b0};
      end
      S_STEP_RD, S_AUG_RD: col_raddr = j0_q;
      S_STEP_GOT: begin
        if (c_own == '0) begin
          col_raddr = c_way;
        end else begin
          col_we      = 1'b1;
          col_waddr   = j0_q;
          col_wdata   = {c_v, c_own, c_way, c_mn, 1'b1};
          day_raddr_o = {la, own_m1[CW-1:0]};
        end
      end
      S_SCAN_GOT: begin
        if (!c_used) begin
          col_we    = 1'b1;
          col_wdata = {c_v, c_own, upd ? j0_q : c_way, nmn, 1'b0};
        end
      end
      S_UPD_GOT: begin
        col_we = 1'b1;
        if (c_used) begin
          col_wdata = {c_v - delta_q, c_own, c_way, c_mn, 1'b1};
        end else begin
          col_wdata = {c_v, c_own, c_way, c_mn - delta_q, 1'b0};
        end
      end
      S_UPD_ROW: begin
        row_we    = 1'b1;
        row_waddr = own_q;
        row_wdata = row_rdata + delta_q;
      end
      S_AUG_GOT: col_raddr = c_way;
      S_AUG_GOT2: begin
        col_we    = 1'b1;
        col_waddr = j0_q;
        col_wdata = {cq_q[CEW-1:PW+2*IW+1], c_own, cq_q[PW+IW:0]};
      end
      S_TOT_GOT: day_raddr_o = {la, own_m1[CW-1:0]};
      default: ;
    endcase
  end

  aes_ram #(.WIDTH(CEW), .DEPTH(MAX_EVENTS + 1)) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (col_wdata),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  aes_ram #(.WIDTH(PW), .DEPTH(MAX_EVENTS + 1)) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      j0_q    <= '0;
      j1_q    <= '0;
      i0_q    <= '0;
      own_q   <= '0;
      size_q  <= '0;
      m_q     <= '0;
      n_q     <= '0;
      cat_q   <= 1'b0;
      total_q <= '0;
      delta_q <= '0;
      u_q     <= '0;
      rday_q  <= '0;
      cq_q    <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            cat_q   <= cat_i;
            m_q     <= m_i;
            n_q     <= n_i;
            size_q  <= (m_i > n_i) ? m_i : n_i;
            j_q     <= '0;
            total_q <= '0;
            state_q <= S_INIT;
          end
        end
        S_INIT: begin
          if (last_j) begin
            i_q     <= IW'(1);
            j_q     <= '0;
            state_q <= S_RST_RD;
          end else begin
            j_q <= j_q + IW'(1);
          end
        end
        S_RST_RD: state_q <= S_RST_WR;
        S_RST_WR: begin
          if (last_j) begin
            j0_q    <= '0;
            state_q <= S_STEP_RD;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_RST_RD;
          end
        end
        S_STEP_RD: state_q <= S_STEP_GOT;
        S_STEP_GOT: begin
          if (c_own == '0) begin
            cq_q    <= col_rdata;
            j1_q    <= c_way;
            state_q <= S_AUG_GOT2;
          end else begin
            i0_q    <= c_own;
            state_q <= S_PREP;
          end
        end
        S_PREP: begin
          u_q     <= $signed(row_rdata);
          rday_q  <= day_rdata_i;
          delta_q <= INF;
          j1_q    <= '0;
          j_q     <= IW'(1);
          state_q <= S_SCAN_RD;
        end
        S_SCAN_RD: state_q <= S_SCAN_GOT;
        S_SCAN_GOT: begin
          if (!c_used && nlt) begin
            delta_q <= nmn;
            j1_q    <= j_q;
          end
          if (last_j) begin
            j_q     <= '0;
            state_q <= S_UPD_RD;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_SCAN_RD;
          end
        end
        S_UPD_RD: state_q <= S_UPD_GOT;
        S_UPD_GOT: begin
          if (c_used) begin
            own_q   <= c_own;
            state_q <= S_UPD_ROW;
          end else if (last_j) begin
            j0_q    <= j1_q;
            state_q <= S_STEP_RD;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_UPD_RD;
          end
        end
        S_UPD_ROW: begin
          if (last_j) begin
            j0_q    <= j1_q;
            state_q <= S_STEP_RD;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_UPD_RD;
          end
        end
        S_AUG_RD: state_q <= S_AUG_GOT;
        S_AUG_GOT: begin
          cq_q    <= col_rdata;
          j1_q    <= c_way;
          state_q <= S_AUG_GOT2;
        end
        S_AUG_GOT2: begin
          j0_q <= j1_q;
          if (j1_q != '0) begin
            state_q <= S_AUG_RD;
          end else if (i_q == size_q) begin
            j_q     <= IW'(1);
            state_q <= S_TOT_RD;
          end else begin
            i_q     <= i_q + IW'(1);
            j_q     <= '0;
            state_q <= S_RST_RD;
          end
        end
        S_TOT_RD: state_q <= S_TOT_GOT;
        S_TOT_GOT: begin
          if (c_own != '0 && c_own <= m_q && j_q <= n_q) begin
            state_q <= S_TOT_D1;
          end else if (last_j) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_TOT_RD;
          end
        end
        S_TOT_D1: begin
          rday_q  <= day_rdata_i;
          state_q <= S_TOT_D2;
        end
        S_TOT_D2: begin
          total_q <= total_q + WW'(wt);
          if (last_j) begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end else begin
            j_q     <= j_q + IW'(1);
            state_q <= S_TOT_RD;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign weight_o = total_q;

endmodule

@@ rtl/core/aes_combine.sv @@
`timescale 1ns / 1ps
module aes_combine #(
  parameter int MAX_EVENTS  = aes_pkg::DEF_MAX_EVENTS,
  parameter int WINDOW_DAYS = aes_pkg::DEF_WINDOW_DAYS,
  localparam int IW = $clog2(MAX_EVENTS + 1),
  localparam int WW = $clog2(WINDOW_DAYS * MAX_EVENTS + 1)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic                      mode_i,
  input  logic [WW-1:0]             w0_i,
  input  logic [WW-1:0]             w1_i,
  input  logic [IW-1:0]             m0_i,
  input  logic [IW-1:0]             n0_i,
  input  logic [IW-1:0]             m1_i,
  input  logic [IW-1:0]             n1_i,
  output logic                      done_o,
  output logic [aes_pkg::SIM_W-1:0] sim_o
);

  localparam int MW = aes_pkg::MUL_W;
  localparam int BW = aes_pkg::MUL_B;
  localparam int FW = aes_pkg::FRAC_W;

  typedef enum logic [3:0] {
    OP_Q0, OP_Q1, OP_W0T, OP_P0, OP_W1T, OP_P1, OP_NUM0, OP_NUM1, OP_DEN0, OP_DEN1
  } op_e;

  typedef enum logic [2:0] {
    C_IDLE, C_LOAD, C_MUL, C_STORE, C_FIN, C_DIV
  } state_e;

  state_e state_q;
  op_e op_q;
  logic [MW-1:0] a_q, acc_q, q0_q, q1_q, r0_q, r1_q, num_q, den_q, rem_q;
  logic [BW-1:0] b_q;
  logic [$clog2(BW)-1:0] cnt_q;
  logic [FW-1:0] quo_q;
  logic [aes_pkg::SIM_W-1:0] sim_q;
  logic done_q;

  logic pres0, pres1, zero;
  logic [IW:0] t0, t1;
  logic [IW+1:0] tsum;
  logic [MW-1:0] opa, rem2;
  logic [BW-1:0] opb, kval;

  assign pres0 = (m0_i != '0) && (n0_i != '0);
  assign pres1 = (m1_i != '0) && (n1_i != '0);
  assign t0    = (IW+1)'(m0_i) + (IW+1)'(n0_i);
  assign t1    = (IW+1)'(m1_i) + (IW+1)'(n1_i);
  assign tsum  = (IW+2)'(t0) + (IW+2)'(t1);
  assign kval  = !mode_i ? BW'(2 * WINDOW_DAYS) * BW'(tsum) :
                 (pres0 && pres1) ? BW'(4 * WINDOW_DAYS) : BW'(2 * WINDOW_DAYS);
  assign zero  = !mode_i ? (tsum == '0) : (!pres0 && !pres1);
  assign rem2  = {rem_q[MW-2:0], 1'b0};

  always_comb begin
    opa = '0;
    opb = '0;
    unique case (op_q)
      OP_Q0: begin
        opa = pres0 ? MW'(m0_i) : MW'(1);
        opb = pres0 ? BW'(n0_i) : BW'(1);
      end
      OP_Q1: begin
        opa = pres1 ? MW'(m1_i) : MW'(1);
        opb = pres1 ? BW'(n1_i) : BW'(1);
      end
      OP_W0T: begin
        opa = MW'(w0_i);
        opb = BW'(t0);
      end
      OP_P0: begin
        opa = r0_q;
        opb = mode_i ? BW'(1) : BW'(t0);
      end
      OP_W1T: begin
        opa = MW'(w1_i);
        opb = BW'(t1);
      end
      OP_P1: begin
        opa = r1_q;
        opb = mode_i ? BW'(1) : BW'(t1);
      end
      OP_NUM0: begin
        opa = r0_q;
        opb = q1_q[BW-1:0];
      end
      OP_NUM1: begin
        opa = r1_q;
        opb = q0_q[BW-1:0];
      end
      OP_DEN0: begin
        opa = q0_q;
        opb = q1_q[BW-1:0];
      end
      OP_DEN1: begin
        opa = den_q;
        opb = kval;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= C_IDLE;
      op_q    <= OP_Q0;
      done_q  <= 1'b0;
      sim_q   <= '0;
      cnt_q   <= '0;
      a_q     <= '0;
      b_q     <= '0;
      acc_q   <= '0;
      q0_q    <= '0;
      q1_q    <= '0;
      r0_q    <= '0;
      r1_q    <= '0;
      num_q   <= '0;
      den_q   <= '0;
      rem_q   <= '0;
      quo_q   <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        C_IDLE: begin
          if (start_i) begin
            op_q    <= OP_Q0;
            state_q <= C_LOAD;
          end
        end
        C_LOAD: begin
          a_q     <= opa;
          b_q     <= opb;
          acc_q   <= '0;
          cnt_q   <= '0;
          state_q <= C_MUL;
        end
        C_MUL: begin
          if (b_q[0]) begin
            acc_q <= acc_q + a_q;
          end
          a_q   <= {a_q[MW-2:0], 1'b0};
          b_q   <= {1'b0, b_q[BW-1:1]};
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == '1) begin
            state_q <= C_STORE;
          end
        end
        C_STORE: begin
          state_q <= C_LOAD;
          unique case (op_q)
            OP_Q0:   q0_q <= acc_q;
            OP_Q1:   q1_q <= acc_q;
            OP_W0T, OP_P0: r0_q <= acc_q;
            OP_W1T, OP_P1: r1_q <= acc_q;
            OP_NUM0: num_q <= acc_q;
            OP_NUM1: num_q <= num_q + acc_q;
            OP_DEN0: den_q <= acc_q;
            OP_DEN1: begin
              den_q   <= acc_q;
              state_q <= C_FIN;
            end
            default: ;
          endcase
          if (op_q != OP_DEN1) begin
            op_q <= op_e'(op_q + 1'b1);
          end
        end
        C_FIN: begin
          if (zero) begin
            sim_q   <= '0;
            done_q  <= 1'b1;
            state_q <= C_IDLE;
          end else if (num_q >= den_q) begin
            sim_q   <= aes_pkg::SIM_ONE;
            done_q  <= 1'b1;
            state_q <= C_IDLE;
          end else begin
            rem_q   <= num_q;
            quo_q   <= '0;
            cnt_q   <= '0;
            state_q <= C_DIV;
          end
        end
        C_DIV: begin
          if (rem2 >= den_q) begin
            rem_q <= rem2 - den_q;
            quo_q <= {quo_q[FW-2:0], 1'b1};
          end else begin
            rem_q <= rem2;
            quo_q <= {quo_q[FW-2:0], 1'b0};
          end
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == $clog2(BW)'(FW - 1)) begin
            state_q <= C_IDLE;
            done_q  <= 1'b1;
          end
        end
        default: state_q <= C_IDLE;
      endcase
      if (state_q == C_DIV && cnt_q == $clog2(BW)'(FW - 1)) begin
        sim_q <= {1'b0, quo_q[FW-2:0], rem2 >= den_q};
      end
    end
  end

  assign done_o = done_q;
  assign sim_o  = sim_q;

endmodule

@@ rtl/core/assignment_event_similarity.sv @@
`timescale 1ns / 1ps
// Day items are taken one per cycle and written into the day memory (four lists of
// MAX_EVENTS entries; items for a full list are dropped and flagged). An item marked
// last stalls input until its result is passed to the output register: each category
// whose two lists are both non-empty runs a Hungarian assignment over size = max(m, n)
// rows; every relaxation step makes sequential read-modify-write passes over the column
// memory, with up to size steps per row. The score is then formed by a bit-serial
// multiplier (ten products) and a 16-step long division. Results wait in an output
// register, and the next list can be loaded while that result is still stalled.
module assignment_event_similarity #(
  parameter int MAX_EVENTS  = aes_pkg::DEF_MAX_EVENTS,
  parameter int WINDOW_DAYS = aes_pkg::DEF_WINDOW_DAYS
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              weight_mode_we_i,
  input  logic                              weight_mode_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [aes_pkg::REQ_W-1:0]         req_type_i,
  input  logic signed [aes_pkg::DAY_W-1:0]  day_i,
  input  logic                              last_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [aes_pkg::SIM_W-1:0]         similarity_o,
  output logic                              overflow_o
);

  localparam int IW  = $clog2(MAX_EVENTS + 1);
  localparam int CW  = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int DAW = CW + 2;
  localparam int WW  = $clog2(WINDOW_DAYS * MAX_EVENTS + 1);

  typedef enum logic [2:0] {
    T_IDLE, T_RUN0, T_WAIT0, T_RUN1, T_WAIT1, T_COMB, T_WAITC, T_OUT
  } state_e;

  state_e state_q;
  logic [IW-1:0] cnt_q [4];
  logic drop_q, mode_q, out_valid_q, ovf_q;
  logic [aes_pkg::SIM_W-1:0] sim_q;
  logic [WW-1:0] w0_q, w1_q;

  logic accept, has_room, pres0, pres1;
  logic [DAW-1:0] day_raddr;
  logic signed [aes_pkg::DAY_W-1:0] day_rdata;
  logic [aes_pkg::DAY_W-1:0] day_rraw;
  logic [IW-1:0] cur_cnt;
  logic solve_start, solve_done, comb_start, comb_done;
  logic [WW-1:0] weight;
  logic [aes_pkg::SIM_W-1:0] comb_sim;

  assign in_stall_o = (state_q != T_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign cur_cnt    = cnt_q[req_type_i];
  assign has_room   = cur_cnt < IW'(MAX_EVENTS);
  assign pres0      = (cnt_q[0] != '0) && (cnt_q[1] != '0);
  assign pres1      = (cnt_q[2] != '0) && (cnt_q[3] != '0);
  assign solve_start = (state_q == T_RUN0 && pres0) || (state_q == T_RUN1 && pres1);
  assign comb_start  = (state_q == T_COMB);
  assign day_rdata   = $signed(day_rraw);

  aes_ram #(.WIDTH(aes_pkg::DAY_W), .DEPTH(4 << CW)) u_day_ram (
    .clk_i   (clk_i),
    .we_i    (accept && has_room),
    .waddr_i ({req_type_i, cur_cnt[CW-1:0]}),
    .wdata_i (day_i),
    .raddr_i (day_raddr),
    .rdata_o (day_rraw)
  );

  aes_solver #(.MAX_EVENTS(MAX_EVENTS), .WINDOW_DAYS(WINDOW_DAYS)) u_solver (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (solve_start),
    .cat_i       (state_q == T_RUN1),
    .m_i         ((state_q == T_RUN1) ? cnt_q[2] : cnt_q[0]),
    .n_i         ((state_q == T_RUN1) ? cnt_q[3] : cnt_q[1]),
    .day_raddr_o (day_raddr),
    .day_rdata_i (day_rdata),
    .done_o      (solve_done),
    .weight_o    (weight)
  );

  aes_combine #(.MAX_EVENTS(MAX_EVENTS), .WINDOW_DAYS(WINDOW_DAYS)) u_combine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (comb_start),
    .mode_i  (mode_q),
    .w0_i    (w0_q),
    .w1_i    (w1_q),
    .m0_i    (cnt_q[0]),
    .n0_i    (cnt_q[1]),
    .m1_i    (cnt_q[2]),
    .n1_i    (cnt_q[3]),
    .done_o  (comb_done),
    .sim_o   (comb_sim)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= T_IDLE;
      cnt_q       <= '{default: '0};
      drop_q      <= 1'b0;
      mode_q      <= 1'b0;
      out_valid_q <= 1'b0;
      ovf_q       <= 1'b0;
      sim_q       <= '0;
      w0_q        <= '0;
      w1_q        <= '0;
    end else begin
      if (weight_mode_we_i) begin
        mode_q <= weight_mode_i;
      end
      if (out_valid_q && !out_stall_i && (state_q != T_OUT)) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        T_IDLE: begin
          if (accept) begin
            if (has_room) begin
              cnt_q[req_type_i] <= cur_cnt + IW'(1);
            end else begin
              drop_q <= 1'b1;
            end
            if (last_i) begin
              state_q <= T_RUN0;
            end
          end
        end
        T_RUN0: begin
          w0_q    <= '0;
          state_q <= pres0 ? T_WAIT0 : T_RUN1;
        end
        T_WAIT0: begin
          if (solve_done) begin
            w0_q    <= weight;
            state_q <= T_RUN1;
          end
        end
        T_RUN1: begin
          w1_q    <= '0;
          state_q <= pres1 ? T_WAIT1 : T_COMB;
        end
        T_WAIT1: begin
          if (solve_done) begin
            w1_q    <= weight;
            state_q <= T_COMB;
          end
        end
        T_COMB: state_q <= T_WAITC;
        T_WAITC: begin
          if (comb_done) begin
            state_q <= T_OUT;
          end
        end
        T_OUT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            sim_q       <= comb_sim;
            ovf_q       <= drop_q;
            drop_q      <= 1'b0;
            cnt_q       <= '{default: '0};
            state_q     <= T_IDLE;
          end
        end
        default: state_q <= T_IDLE;
      endcase
    end
  end

  assign out_valid_o  = out_valid_q;
  assign similarity_o = sim_q;
  assign overflow_o   = ovf_q;

endmodule
